/* design/stwm_pkg.sv */
`default_nettype none
package stwm_pkg;

   localparam int HalfPeriodWidth = 16;
   localparam int WaitWidth       = 24;
   localparam int CsrDataWidth    = 24;

   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd5;
   localparam logic [WaitWidth-1:0]       WaitReset       = 24'd500000;

   typedef enum logic [0:0] {
      CSR_HALF_PERIOD = 1'b0,
      CSR_CONV_WAIT   = 1'b1
   } csr_index_type;

   localparam logic [7:0] CmdTemperature = 8'h03;
   localparam logic [7:0] CmdHumidity    = 8'h05;

   localparam logic [3:0] ResetClocks = 4'd9;
   localparam logic [3:0] StartSteps  = 4'd7;
   localparam logic [3:0] ByteBits    = 4'd8;
   localparam logic [1:0] LastByte    = 2'd2;

   // start sequence levels, one bit per half period, top bit unused
   localparam logic [7:0] StartSck  = 8'b0011_0110;
   localparam logic [7:0] StartData = 8'b0110_0011;

   typedef enum logic [12:0] {
      PH_IDLE    = 13'b0_0000_0000_0001,
      PH_RST_HI  = 13'b0_0000_0000_0010,
      PH_RST_LO  = 13'b0_0000_0000_0100,
      PH_START   = 13'b0_0000_0000_1000,
      PH_CMD_HI  = 13'b0_0000_0001_0000,
      PH_CMD_LO  = 13'b0_0000_0010_0000,
      PH_ACK     = 13'b0_0000_0100_0000,
      PH_WAIT    = 13'b0_0000_1000_0000,
      PH_RD_HI   = 13'b0_0001_0000_0000,
      PH_RD_LO   = 13'b0_0010_0000_0000,
      PH_RACK_HI = 13'b0_0100_0000_0000,
      PH_RACK_LO = 13'b0_1000_0000_0000,
      PH_DONE    = 13'b1_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic clock_pin;
      logic data_drive_enable;
      logic data_pin_out;
      logic busy;
      logic done;
   } pins_type;

   typedef struct packed {
      logic start_req;
      logic measure_humidity;
      logic reset_first;
      logic data_pin_in;
   } tick_type;

endpackage
`default_nettype wire

/* design/stwm_seq.sv */
`default_nettype none
module stwm_seq (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   advance,
   input  wire stwm_pkg::tick_type               tick,
   input  wire [stwm_pkg::HalfPeriodWidth-1:0]   half_period,
   input  wire [stwm_pkg::WaitWidth-1:0]         conv_wait,
   output stwm_pkg::pins_type                    pins,
   output logic [15:0]                           raw_value,
   output logic [7:0]                            crc_byte,
   output logic [1:0]                            error_count
);
   import stwm_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [WaitWidth-1:0]    tick_ff, tick_in;
   logic [3:0]              bit_ff, bit_in;
   logic [7:0]              shift_ff, shift_in;
   logic [1:0]              byte_ff, byte_in;
   logic [15:0]             value_ff, value_in;
   logic [7:0]              crc_ff, crc_in;
   logic [1:0]              error_ff, error_in;
   logic                    mode_ff, mode_in;

   logic [WaitWidth-1:0]    len_raw;
   logic [WaitWidth-1:0]    len;
   logic [WaitWidth:0]      tick_inc;
   logic                    ph_end;
   logic [1:0]              error_inc;

   // phase length, end-of-phase test and saturating error increment
   always_comb begin
      len_raw  = (phase_ff == PH_WAIT) ? conv_wait
                                       : {{(WaitWidth-HalfPeriodWidth){1'b0}}, half_period};
      len      = (len_raw == '0) ? {{(WaitWidth-1){1'b0}}, 1'b1} : len_raw;
      tick_inc = {1'b0, tick_ff} + {{WaitWidth{1'b0}}, 1'b1};
      ph_end   = tick_inc >= {1'b0, len};
      error_inc = (error_ff == 2'd3) ? error_ff : error_ff + 2'd1;
   end

   always_comb begin
      pins = '{clock_pin: 1'b0, data_drive_enable: 1'b1, data_pin_out: 1'b1,
               busy: 1'b1, done: 1'b0};
      case (phase_ff)
         PH_RST_HI:  pins.clock_pin = 1'b1;
         PH_RST_LO:  ;
         PH_START: begin
            pins.clock_pin    = StartSck[bit_ff[2:0]];
            pins.data_pin_out = StartData[bit_ff[2:0]];
         end
         PH_CMD_HI: begin
            pins.clock_pin    = 1'b1;
            pins.data_pin_out = shift_ff[7];
         end
         PH_CMD_LO:  pins.data_pin_out = shift_ff[7];
         PH_ACK, PH_RD_HI: begin
            pins.clock_pin         = 1'b1;
            pins.data_drive_enable = 1'b0;
         end
         PH_WAIT, PH_RD_LO: pins.data_drive_enable = 1'b0;
         PH_RACK_HI: begin
            pins.clock_pin    = 1'b1;
            pins.data_pin_out = (byte_ff >= LastByte);
         end
         PH_RACK_LO: pins.data_pin_out = (byte_ff >= LastByte);
         PH_DONE: begin
            pins.busy = 1'b0;
            pins.done = 1'b1;
         end
         default:    pins.busy = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      byte_in  = byte_ff;
      value_in = value_ff;
      crc_in   = crc_ff;
      error_in = error_ff;
      mode_in  = mode_ff;
      if (phase_ff != PH_IDLE && phase_ff != PH_DONE) begin
         tick_in = ph_end ? '0 : tick_inc[WaitWidth-1:0];
      end
      case (phase_ff)
         PH_RST_HI: if (ph_end) phase_in = PH_RST_LO;
         PH_RST_LO: begin
            if (ph_end) begin
               if (bit_ff + 4'd1 >= ResetClocks) begin
                  bit_in   = '0;
                  phase_in = PH_START;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_RST_HI;
               end
            end
         end
         PH_START: begin
            if (ph_end) begin
               if (bit_ff + 4'd1 >= StartSteps) begin
                  bit_in   = '0;
                  shift_in = mode_ff ? CmdHumidity : CmdTemperature;
                  phase_in = PH_CMD_HI;
               end else begin
                  bit_in = bit_ff + 4'd1;
               end
            end
         end
         PH_CMD_HI: if (ph_end) phase_in = PH_CMD_LO;
         PH_CMD_LO: begin
            if (ph_end) begin
               shift_in = {shift_ff[6:0], 1'b0};
               if (bit_ff + 4'd1 >= ByteBits) begin
                  bit_in   = '0;
                  phase_in = PH_ACK;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_CMD_HI;
               end
            end
         end
         PH_ACK: begin
            if (ph_end) begin
               if (tick.data_pin_in) error_in = error_inc;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (ph_end) begin
               if (tick.data_pin_in) error_in = error_inc;
               byte_in  = '0;
               bit_in   = '0;
               shift_in = '0;
               phase_in = PH_RD_HI;
            end
         end
         PH_RD_HI: begin
            if (ph_end) begin
               shift_in = {shift_ff[6:0], tick.data_pin_in};
               phase_in = PH_RD_LO;
            end
         end
         PH_RD_LO: begin
            if (ph_end) begin
               if (bit_ff + 4'd1 >= ByteBits) begin
                  bit_in = '0;
                  case (byte_ff)
                     2'd0:    value_in = {shift_ff, value_ff[7:0]};
                     2'd1:    value_in = {value_ff[15:8], shift_ff};
                     default: crc_in   = shift_ff;
                  endcase
                  phase_in = PH_RACK_HI;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = PH_RD_HI;
               end
            end
         end
         PH_RACK_HI: if (ph_end) phase_in = PH_RACK_LO;
         PH_RACK_LO: begin
            if (ph_end) begin
               if (byte_ff >= LastByte) begin
                  byte_in  = '0;
                  phase_in = PH_DONE;
               end else begin
                  byte_in  = byte_ff + 2'd1;
                  shift_in = '0;
                  phase_in = PH_RD_HI;
               end
            end
         end
         PH_DONE: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
            if (tick.start_req) begin
               mode_in  = tick.measure_humidity;
               error_in = '0;
               value_in = '0;
               crc_in   = '0;
               bit_in   = '0;
               byte_in  = '0;
               shift_in = '0;
               phase_in = tick.reset_first ? PH_RST_HI : PH_START;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         byte_ff  <= '0;
         value_ff <= '0;
         crc_ff   <= '0;
         error_ff <= '0;
         mode_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         byte_ff  <= byte_in;
         value_ff <= value_in;
         crc_ff   <= crc_in;
         error_ff <= error_in;
         mode_ff  <= mode_in;
      end
   end

   assign raw_value   = value_ff;
   assign crc_byte    = crc_ff;
   assign error_count = error_ff;

endmodule
`default_nettype wire

/* design/sensor_two_wire_measure_master_top.sv */
// Two-wire humidity/temperature sensor measurement master.
// Request channel (req_*): one request per timer tick, carrying the start
// request, mode, connection-reset flag and the sampled DATA level.
// Response channel (rsp_*): exactly one response per request, giving the
// SCK/DATA pin levels, busy/done flags and the last measurement (raw value,
// CRC byte, error count) as they stood before that request was applied.
// The response is registered: a request accepted at an edge shows its response
// in the cycle after. Throughput is one request per cycle; the response
// register lets a new request in whenever the held response is taken in
// the same cycle or the register is empty.
// When the receiver stalls, req_ready drops and the sequencer freezes,
// so no tick is lost; time on the pins is counted in requests, not clocks.
// Configuration: csr_wr_en writes half-period (index 0) or conversion wait
// (index 1) at once; write only while idle.
// Synchronous reset returns the sequencer to idle, clears the measurement
// registers, restores the timing defaults and empties the response register.
`default_nettype none
module sensor_two_wire_measure_master_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_start_req,
   input  wire                                req_measure_humidity,
   input  wire                                req_reset_first,
   input  wire                                req_data_pin_in,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_clock_pin,
   output logic                               rsp_data_drive_enable,
   output logic                               rsp_data_pin_out,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [15:0]                        rsp_raw_value,
   output logic [7:0]                         rsp_crc_byte,
   output logic [1:0]                         rsp_error_count,
   input  wire                                csr_wr_en,
   input  wire                                csr_index,
   input  wire [stwm_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import stwm_pkg::*;

   logic [HalfPeriodWidth-1:0] half_period_ff;
   logic [WaitWidth-1:0]       conv_wait_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   pins_type                   pins_ff, pins;
   logic [15:0]                value_ff, value;
   logic [7:0]                 crc_ff, crc;
   logic [1:0]                 error_ff, error;
   tick_type                   tick;
   logic                       advance;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;
   assign tick      = '{start_req: req_start_req, measure_humidity: req_measure_humidity,
                        reset_first: req_reset_first, data_pin_in: req_data_pin_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HalfPeriodReset;
         conv_wait_ff   <= WaitReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[HalfPeriodWidth-1:0];
            CSR_CONV_WAIT:   conv_wait_ff   <= csr_wdata[WaitWidth-1:0];
            default:         ;
         endcase
      end
   end

   stwm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .tick        (tick),
      .half_period (half_period_ff),
      .conv_wait   (conv_wait_ff),
      .pins        (pins),
      .raw_value   (value),
      .crc_byte    (crc),
      .error_count (error)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pins_ff  <= pins;
         value_ff <= value;
         crc_ff   <= crc;
         error_ff <= error;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_clock_pin         = pins_ff.clock_pin;
   assign rsp_data_drive_enable = pins_ff.data_drive_enable;
   assign rsp_data_pin_out      = pins_ff.data_pin_out;
   assign rsp_busy_res          = pins_ff.busy;
   assign rsp_done_res          = pins_ff.done;
   assign rsp_raw_value         = value_ff;
   assign rsp_crc_byte          = crc_ff;
   assign rsp_error_count       = error_ff;

endmodule
`default_nettype wire

/* tb/tb_sensor_two_wire_measure_master_top.sv */
`default_nettype none
module tb_sensor_two_wire_measure_master_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stwm_pkg::*;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned ReportLimit = 40;

   typedef enum int {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_mode_type;

   typedef struct packed {
      pins_type    pins;
      logic [15:0] raw_value;
      logic [7:0]  crc_byte;
      logic [1:0]  error_count;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic     req_valid = 1'b0;
   logic     req_ready;
   tick_type req_item  = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_clock_pin, rsp_data_drive_enable, rsp_data_pin_out;
   logic        rsp_busy_res, rsp_done_res;
   logic [15:0] rsp_raw_value;
   logic [7:0]  rsp_crc_byte;
   logic [1:0]  rsp_error_count;

   logic                    csr_wr_en = 1'b0;
   csr_index_type           csr_idx   = CSR_HALF_PERIOD;
   logic [CsrDataWidth-1:0] csr_data  = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycles        = 0;
   int unsigned queued        = 0;
   int unsigned mismatches    = 0;

   tick_type    ticks_to_send[$];
   reading_type readings_due[$];

   // sequencer mirror
   logic [HalfPeriodWidth-1:0] half_q   = HalfPeriodReset;
   logic [WaitWidth-1:0]       conv_q   = WaitReset;
   phase_type                  ph       = PH_IDLE;
   logic [23:0]                tick_cnt = '0;
   logic [3:0]                 bit_idx  = '0;
   logic [7:0]                 shift_q  = '0;
   logic [1:0]                 byte_idx = '0;
   logic [15:0]                value_q  = '0;
   logic [7:0]                 crc_q    = '0;
   logic [1:0]                 err_q    = '0;
   logic                       mode_q   = 1'b0;

   sensor_two_wire_measure_master_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_start_req         (req_item.start_req),
      .req_measure_humidity  (req_item.measure_humidity),
      .req_reset_first       (req_item.reset_first),
      .req_data_pin_in       (req_item.data_pin_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_clock_pin         (rsp_clock_pin),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_data_pin_out      (rsp_data_pin_out),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_raw_value         (rsp_raw_value),
      .rsp_crc_byte          (rsp_crc_byte),
      .rsp_error_count       (rsp_error_count),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_idx),
      .csr_wdata             (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // true on the last tick of a phase lasting len ticks
   function automatic bit phase_over(input int unsigned len);
      int unsigned n;
      n = (len == 0) ? 1 : len;
      if (32'(tick_cnt) + 1 >= n) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 24'd1;
      return 1'b0;
   endfunction

   function automatic void add_error();
      if (err_q < 2'd3) err_q = err_q + 2'd1;
   endfunction

   function automatic void sequencer_step(input tick_type t, output reading_type o);
      int unsigned hp;
      hp = 32'(half_q);
      o.pins.clock_pin         = 1'b0;
      o.pins.data_drive_enable = 1'b1;
      o.pins.data_pin_out      = 1'b1;
      o.pins.busy              = 1'b1;
      o.pins.done              = 1'b0;
      case (ph)
         PH_RST_HI: o.pins.clock_pin = 1'b1;
         PH_RST_LO: ;
         PH_START: begin
            if (bit_idx < StartSteps) begin
               o.pins.clock_pin    = StartSck[bit_idx[2:0]];
               o.pins.data_pin_out = StartData[bit_idx[2:0]];
            end
         end
         PH_CMD_HI: begin
            o.pins.clock_pin    = 1'b1;
            o.pins.data_pin_out = shift_q[7];
         end
         PH_CMD_LO: o.pins.data_pin_out = shift_q[7];
         PH_ACK, PH_RD_HI: begin
            o.pins.clock_pin         = 1'b1;
            o.pins.data_drive_enable = 1'b0;
         end
         PH_WAIT, PH_RD_LO: o.pins.data_drive_enable = 1'b0;
         PH_RACK_HI: begin
            o.pins.clock_pin    = 1'b1;
            o.pins.data_pin_out = (byte_idx < LastByte) ? 1'b0 : 1'b1;
         end
         PH_RACK_LO: o.pins.data_pin_out = (byte_idx < LastByte) ? 1'b0 : 1'b1;
         PH_DONE: begin
            o.pins.busy = 1'b0;
            o.pins.done = 1'b1;
         end
         default: o.pins.busy = 1'b0;
      endcase
      o.raw_value   = value_q;
      o.crc_byte    = crc_q;
      o.error_count = err_q;

      case (ph)
         PH_RST_HI: if (phase_over(hp)) ph = PH_RST_LO;
         PH_RST_LO: begin
            if (phase_over(hp)) begin
               bit_idx = bit_idx + 4'd1;
               if (bit_idx >= ResetClocks) begin
                  bit_idx = '0;
                  ph      = PH_START;
               end else begin
                  ph = PH_RST_HI;
               end
            end
         end
         PH_START: begin
            if (phase_over(hp)) begin
               bit_idx = bit_idx + 4'd1;
               if (bit_idx >= StartSteps) begin
                  bit_idx = '0;
                  shift_q = mode_q ? CmdHumidity : CmdTemperature;
                  ph      = PH_CMD_HI;
               end
            end
         end
         PH_CMD_HI: if (phase_over(hp)) ph = PH_CMD_LO;
         PH_CMD_LO: begin
            if (phase_over(hp)) begin
               shift_q = shift_q << 1;
               bit_idx = bit_idx + 4'd1;
               if (bit_idx >= ByteBits) begin
                  bit_idx = '0;
                  ph      = PH_ACK;
               end else begin
                  ph = PH_CMD_HI;
               end
            end
         end
         PH_ACK: begin
            if (phase_over(hp)) begin
               if (t.data_pin_in) add_error();
               ph = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (phase_over(32'(conv_q))) begin
               if (t.data_pin_in) add_error();
               byte_idx = '0;
               bit_idx  = '0;
               shift_q  = '0;
               ph       = PH_RD_HI;
            end
         end
         PH_RD_HI: begin
            if (phase_over(hp)) begin
               shift_q = {shift_q[6:0], t.data_pin_in};
               ph      = PH_RD_LO;
            end
         end
         PH_RD_LO: begin
            if (phase_over(hp)) begin
               bit_idx = bit_idx + 4'd1;
               if (bit_idx >= ByteBits) begin
                  bit_idx = '0;
                  if (byte_idx == 2'd0) value_q[15:8] = shift_q;
                  else if (byte_idx == 2'd1) value_q[7:0] = shift_q;
                  else crc_q = shift_q;
                  ph = PH_RACK_HI;
               end else begin
                  ph = PH_RD_HI;
               end
            end
         end
         PH_RACK_HI: if (phase_over(hp)) ph = PH_RACK_LO;
         PH_RACK_LO: begin
            if (phase_over(hp)) begin
               if (byte_idx >= LastByte) begin
                  byte_idx = '0;
                  ph       = PH_DONE;
               end else begin
                  byte_idx = byte_idx + 2'd1;
                  shift_q  = '0;
                  ph       = PH_RD_HI;
               end
            end
         end
         PH_DONE: begin
            ph       = PH_IDLE;
            tick_cnt = '0;
         end
         default: begin
            ph       = PH_IDLE;
            tick_cnt = '0;
            if (t.start_req) begin
               mode_q   = t.measure_humidity;
               err_q    = '0;
               value_q  = '0;
               crc_q    = '0;
               bit_idx  = '0;
               byte_idx = '0;
               shift_q  = '0;
               ph       = t.reset_first ? PH_RST_HI : PH_START;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : drive
      reading_type r;
      tick_type    nxt;
      bit          fire;
      if (reset) begin
         req_valid <= 1'b0;
         readings_due.delete();
         half_q   = HalfPeriodReset;
         conv_q   = WaitReset;
         ph       = PH_IDLE;
         tick_cnt = '0;
         bit_idx  = '0;
         shift_q  = '0;
         byte_idx = '0;
         value_q  = '0;
         crc_q    = '0;
         err_q    = '0;
         mode_q   = 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            sequencer_step(req_item, r);
            readings_due.push_back(r);
         end
         if (!req_valid || fire) begin
            if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = ticks_to_send.pop_front();
               req_item  <= nxt;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void match(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
      if (got !== want) begin
         if (mismatches < ReportLimit)
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      reading_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               if (mismatches < ReportLimit)
                  $display("%0t: response with none expected, expected nothing got %0h",
                           $time, rsp_raw_value);
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               match("clock_pin", 16'(want.pins.clock_pin), 16'(rsp_clock_pin));
               match("data_drive_enable", 16'(want.pins.data_drive_enable),
                     16'(rsp_data_drive_enable));
               match("data_pin_out", 16'(want.pins.data_pin_out), 16'(rsp_data_pin_out));
               match("busy_res", 16'(want.pins.busy), 16'(rsp_busy_res));
               match("done_res", 16'(want.pins.done), 16'(rsp_done_res));
               match("raw_value", want.raw_value, rsp_raw_value);
               match("crc_byte", 16'(want.crc_byte), 16'(rsp_crc_byte));
               match("error_count", 16'(want.error_count), 16'(rsp_error_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic tick_type make_tick(input bit s, input bit h, input bit r, input bit d);
      tick_type t;
      t.start_req        = s;
      t.measure_humidity = h;
      t.reset_first      = r;
      t.data_pin_in      = d;
      return t;
   endfunction

   task automatic queue_tick(input tick_type t);
      ticks_to_send.push_back(t);
      queued++;
   endtask

   task automatic queue_idle(input int unsigned n);
      repeat (n) queue_tick(make_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1))));
   endtask

   function automatic bit data_level(input din_mode_type m);
      case (m)
         DIN_LOW:  return 1'b0;
         DIN_HIGH: return 1'b1;
         default:  return 1'($urandom_range(1));
      endcase
   endfunction

   // start request, the whole busy stretch, then the done tick
   task automatic queue_measurement(input bit hum, input bit rst, input din_mode_type m,
                                    input int unsigned busy_start_pct, input bit start_on_done);
      int unsigned h, w, n;
      h = (half_q == '0) ? 1 : 32'(half_q);
      w = (conv_q == '0) ? 1 : 32'(conv_q);
      n = (rst ? 18 * h : 0) + 78 * h + w;
      queue_tick(make_tick(1'b1, hum, rst, data_level(m)));
      repeat (n)
         queue_tick(make_tick($urandom_range(99) < busy_start_pct, 1'($urandom_range(1)),
                              1'($urandom_range(1)), data_level(m)));
      queue_tick(make_tick(start_on_done, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           data_level(m)));
   endtask

   task automatic random_measurements(input int unsigned count);
      int unsigned  target;
      din_mode_type m;
      target = queued + count;
      while (queued < target) begin
         case ($urandom_range(9))
            0:       m = DIN_LOW;
            1:       m = DIN_HIGH;
            default: m = DIN_RANDOM;
         endcase
         queue_measurement(1'($urandom_range(1)), 1'($urandom_range(1)), m,
                           $urandom_range(10), $urandom_range(3) == 0);
         queue_idle($urandom_range(3));
      end
   endtask

   // checked between edges, once every update of the edge has landed
   task automatic drain();
      do
         @(negedge clock);
      while (ticks_to_send.size() != 0 || req_valid || readings_due.size() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_idx   <= idx;
      csr_data  <= val;
      if (idx == CSR_HALF_PERIOD) half_q = val[HalfPeriodWidth-1:0];
      else conv_q = val[WaitWidth-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_timing(input int unsigned hp, input int unsigned cw,
                             input int unsigned send_pct, input int unsigned hold_pct);
      send_idle_pct <= send_pct;
      stall_pct     <= hold_pct;
      write_csr(CSR_HALF_PERIOD, CsrDataWidth'(hp));
      write_csr(CSR_CONV_WAIT, CsrDataWidth'(cw));
   endtask

   initial begin : run
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // idle levels straight out of reset
      queue_tick(make_tick(0, 0, 0, 0));
      queue_tick(make_tick(0, 1, 1, 1));
      drain();

      // zero timing acts as one tick; all-low and all-high DATA; starts while busy
      set_timing(0, 0, 0, 0);
      queue_measurement(0, 0, DIN_LOW, 0, 0);
      queue_measurement(1, 1, DIN_HIGH, 100, 1);
      queue_measurement(0, 1, DIN_RANDOM, 20, 0);
      queue_idle(1);
      queue_measurement(1, 0, DIN_RANDOM, 0, 1);
      queue_idle(2);
      drain();

      set_timing(1, 1, 0, 0);
      random_measurements(150);
      drain();
      set_timing(1, 3, 71, 0);
      random_measurements(150);
      drain();
      set_timing(2, 17, 0, 71);
      random_measurements(150);
      drain();
      set_timing(3, 2, 26, 26);
      random_measurements(150);
      drain();

      // widest settings, idle requests only
      set_timing(65535, 16777215, 26, 26);
      queue_idle(20);
      drain();

      set_timing(1, 6, 0, 0);
      random_measurements(100);
      drain();
      random_measurements(100);
      drain();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
